// File: design/prc_pkg.sv
// prc_pkg: shared codes, field widths and types for the path result cache
// no dependencies; used by path_result_cache_fifo_unit
`timescale 1ns / 1ps

package prc_pkg;

    // request codes
    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;
    localparam logic [1:0] REQ_STATS  = 2'd3;

    // result kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_STATS  = 1'b1;

    // fixed field widths
    localparam int COORD_W = 4;
    localparam int KEY_W   = 16;
    localparam int LEN_W   = 7;
    localparam int NODE_W  = 8;
    localparam int CNT_W   = 32;
    localparam int RATE_W  = 7;

    // hit rate scale and divider sizing
    localparam int RATE_SCALE = 100;
    localparam int TOTAL_W    = CNT_W + 1;
    localparam int PROD_W     = CNT_W + RATE_W;
    localparam int STEP_W     = 3;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [LEN_W-1:0] t_len;

endpackage

// File: design/path_result_cache_fifo_unit.sv
// path_result_cache_fifo_unit: fully associative path cache with round-robin replacement
// depends on prc_pkg for request codes, widths and types
`timescale 1ns / 1ps

// Command-style block: a request is taken on a clock edge with start high and
// busy low. Store and clear finish in the cycle they are taken and busy stays
// low, so store nodes can be sent every cycle. A lookup keeps busy high for the
// key compare and the length memory read, and on a hit of a non-empty path of
// L nodes also while the nodes stream out, one node per cycle out of the node
// memory, whose read port is used once per cycle. A statistics request keeps
// busy high for the multiply by 100 and the bit-per-cycle divider that forms
// the hit rate. Each result shows on the o_ result ports for exactly one cycle
// with o_result_valid high, in the cycle after the block produced it; the
// receiver cannot stall, so every strobed result must be taken
// when it appears.
module path_result_cache_fifo_unit #(
    parameter int ENTRY_COUNT    = 8,
    parameter int MAX_PATH_NODES = 32,
    parameter int NODE_BITS      = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_req_type,
    input  logic [prc_pkg::COORD_W-1:0]   i_start_x,
    input  logic [prc_pkg::COORD_W-1:0]   i_start_y,
    input  logic [prc_pkg::COORD_W-1:0]   i_goal_x,
    input  logic [prc_pkg::COORD_W-1:0]   i_goal_y,
    input  logic [prc_pkg::LEN_W-1:0]     i_path_length,
    input  logic [prc_pkg::NODE_W-1:0]    i_node_value,
    output logic                          o_result_valid,
    output logic                          o_result_kind,
    output logic                          o_hit,
    output logic [prc_pkg::LEN_W-1:0]     o_path_length_out,
    output logic [prc_pkg::NODE_W-1:0]    o_node_out,
    output logic                          o_last_result,
    output logic [prc_pkg::CNT_W-1:0]     o_hit_count,
    output logic [prc_pkg::CNT_W-1:0]     o_miss_count,
    output logic [prc_pkg::RATE_W-1:0]    o_hit_rate
);

    localparam int EW    = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int NW    = (MAX_PATH_NODES > 1) ? $clog2(MAX_PATH_NODES) : 1;
    localparam int CW    = $clog2(MAX_PATH_NODES + 1);
    localparam int NB    = (NODE_BITS < prc_pkg::NODE_W) ? NODE_BITS : prc_pkg::NODE_W;
    localparam int AW    = EW + NW;
    localparam int DEPTH = ENTRY_COUNT << NW;

    localparam logic [EW-1:0] LAST_ENTRY = EW'(ENTRY_COUNT - 1);
    localparam prc_pkg::t_len MAX_LEN    = prc_pkg::LEN_W'(MAX_PATH_NODES);

    // controller states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_NODE = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;

    // storage
    logic [NB-1:0]         mem_nodes [0:DEPTH-1];
    prc_pkg::t_len         mem_len   [0:ENTRY_COUNT-1];
    prc_pkg::t_key         r_entry_key [0:ENTRY_COUNT-1];
    logic [ENTRY_COUNT-1:0] r_valid, n_valid;

    // control registers
    logic [2:0]                   r_state, n_state;
    logic [EW-1:0]                r_wp, n_wp;
    logic [CW-1:0]                r_store_cnt, n_store_cnt;
    prc_pkg::t_len                r_store_len, n_store_len;
    logic [prc_pkg::CNT_W-1:0]    r_hits, n_hits;
    logic [prc_pkg::CNT_W-1:0]    r_misses, n_misses;
    prc_pkg::t_key                r_key, n_key;
    logic                         r_found, n_found;
    logic [EW-1:0]                r_idx, n_idx;
    prc_pkg::t_len                r_len, n_len;
    logic [NW-1:0]                r_j, n_j;
    logic [prc_pkg::PROD_W-1:0]   r_prod, n_prod;
    logic [prc_pkg::PROD_W-1:0]   r_div, n_div;
    logic                         r_tot_zero, n_tot_zero;
    logic [prc_pkg::RATE_W-1:0]   r_quot, n_quot;
    logic [prc_pkg::STEP_W-1:0]   r_step, n_step;

    // memory read data
    logic [NB-1:0]  r_node_rd;
    prc_pkg::t_len  r_len_rd;

    // output registers
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_kind, n_out_kind;
    logic                          r_out_hit, n_out_hit;
    prc_pkg::t_len                 r_out_len, n_out_len;
    logic [NB-1:0]                 r_out_node, n_out_node;
    logic                          r_out_last, n_out_last;
    logic [prc_pkg::CNT_W-1:0]     r_out_hc, n_out_hc;
    logic [prc_pkg::CNT_W-1:0]     r_out_mc, n_out_mc;
    logic [prc_pkg::RATE_W-1:0]    r_out_rate, n_out_rate;

    // combinational helpers
    logic                         accept;
    prc_pkg::t_key                in_key;
    prc_pkg::t_len                len_sat;
    prc_pkg::t_len                eff_len;
    logic                         st_first;
    logic                         st_take;
    logic                         node_we;
    logic                         key_we;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic [CW-1:0]                cnt_inc;
    logic                         match_found;
    logic [EW-1:0]                match_idx;
    logic                         div_ge;
    logic [prc_pkg::RATE_W-1:0]   quot_next;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign in_key = {i_goal_y, i_goal_x, i_start_y, i_start_x};

    // store bookkeeping for the current node
    assign st_first = (r_store_cnt == '0);
    assign len_sat  = (i_path_length > MAX_LEN) ? MAX_LEN : i_path_length;
    assign eff_len  = st_first ? len_sat : r_store_len;
    assign st_take  = accept && (i_req_type == prc_pkg::REQ_STORE);
    assign key_we   = st_take && st_first;
    assign node_we  = st_take && (prc_pkg::LEN_W'(r_store_cnt) < eff_len);
    assign cnt_inc  = node_we ? (r_store_cnt + CW'(1)) : r_store_cnt;
    assign wr_addr  = {r_wp, r_store_cnt[NW-1:0]};

    // node read address: first node after the length read, then the next one
    assign rd_addr = (r_state == S_NODE) ? {r_idx, r_j + NW'(1)} : {r_idx, NW'(0)};

    // associative compare, lowest valid index wins
    always_comb begin
        match_found = 1'b0;
        match_idx   = '0;
        for (int e = ENTRY_COUNT - 1; e >= 0; e--) begin
            if (r_valid[e] && (r_entry_key[e] == r_key)) begin
                match_found = 1'b1;
                match_idx   = EW'(e);
            end
        end
    end

    // one restoring divider step
    assign div_ge    = (r_prod >= r_div);
    assign quot_next = {r_quot[prc_pkg::RATE_W-2:0], div_ge};

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_wp        = r_wp;
        n_store_cnt = r_store_cnt;
        n_store_len = r_store_len;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_key       = r_key;
        n_found     = r_found;
        n_idx       = r_idx;
        n_len       = r_len;
        n_j         = r_j;
        n_prod      = r_prod;
        n_div       = r_div;
        n_tot_zero  = r_tot_zero;
        n_quot      = r_quot;
        n_step      = r_step;
        n_out_valid = 1'b0;
        n_out_kind  = prc_pkg::KIND_LOOKUP;
        n_out_hit   = 1'b0;
        n_out_len   = '0;
        n_out_node  = '0;
        n_out_last  = 1'b1;
        n_out_hc    = '0;
        n_out_mc    = '0;
        n_out_rate  = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        prc_pkg::REQ_LOOKUP: begin
                            n_key   = in_key;
                            n_state = S_CMP;
                        end
                        prc_pkg::REQ_STORE: begin
                            if (st_first) begin
                                n_valid[r_wp] = 1'b0;
                            end
                            n_store_len = eff_len;
                            n_store_cnt = cnt_inc;
                            if (prc_pkg::LEN_W'(cnt_inc) >= eff_len) begin
                                n_valid[r_wp] = 1'b1;
                                n_wp          = (r_wp == LAST_ENTRY) ? '0 : r_wp + EW'(1);
                                n_store_cnt   = '0;
                            end
                        end
                        prc_pkg::REQ_CLEAR: begin
                            n_valid     = '0;
                            n_wp        = '0;
                            n_store_cnt = '0;
                        end
                        default: begin
                            n_state = S_MUL;
                        end
                    endcase
                end
            end
            S_CMP: begin
                n_found = match_found;
                n_idx   = match_idx;
                if (match_found) begin
                    n_hits = r_hits + 32'd1;
                end else begin
                    n_misses = r_misses + 32'd1;
                end
                n_state = S_LEN;
            end
            S_LEN: begin
                if (!r_found || (r_len_rd == '0)) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_found;
                    n_state     = S_IDLE;
                end else begin
                    n_len   = r_len_rd;
                    n_j     = '0;
                    n_state = S_NODE;
                end
            end
            S_NODE: begin
                n_out_valid = 1'b1;
                n_out_hit   = 1'b1;
                n_out_len   = r_len;
                n_out_node  = r_node_rd;
                n_out_last  = (prc_pkg::LEN_W'(r_j) == r_len - prc_pkg::LEN_W'(1));
                if (n_out_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_j = r_j + NW'(1);
                end
            end
            S_MUL: begin
                n_prod     = prc_pkg::PROD_W'(r_hits) * prc_pkg::PROD_W'(prc_pkg::RATE_SCALE);
                n_div      = prc_pkg::PROD_W'({1'b0, r_hits} + {1'b0, r_misses})
                             << (prc_pkg::RATE_W - 1);
                n_tot_zero = (r_hits == '0) && (r_misses == '0);
                n_quot     = '0;
                n_step     = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                if (div_ge) begin
                    n_prod = r_prod - r_div;
                end
                n_div  = r_div >> 1;
                n_quot = quot_next;
                n_step = r_step + prc_pkg::STEP_W'(1);
                if (r_step == prc_pkg::STEP_W'(prc_pkg::RATE_W - 1)) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = prc_pkg::KIND_STATS;
                    n_out_hc    = r_hits;
                    n_out_mc    = r_misses;
                    n_out_rate  = r_tot_zero ? '0 : quot_next;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_wp        <= '0;
            r_store_cnt <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_wp        <= n_wp;
            r_store_cnt <= n_store_cnt;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath and output registers
    always_ff @(posedge i_clk) begin
        r_store_len <= n_store_len;
        r_key       <= n_key;
        r_found     <= n_found;
        r_idx       <= n_idx;
        r_len       <= n_len;
        r_j         <= n_j;
        r_prod      <= n_prod;
        r_div       <= n_div;
        r_tot_zero  <= n_tot_zero;
        r_quot      <= n_quot;
        r_step      <= n_step;
        r_out_kind  <= n_out_kind;
        r_out_hit   <= n_out_hit;
        r_out_len   <= n_out_len;
        r_out_node  <= n_out_node;
        r_out_last  <= n_out_last;
        r_out_hc    <= n_out_hc;
        r_out_mc    <= n_out_mc;
        r_out_rate  <= n_out_rate;
    end

    // entry keys and lengths, written at the write pointer on the first node
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_entry_key[r_wp] <= in_key;
            mem_len[r_wp]     <= len_sat;
        end
        r_len_rd <= mem_len[match_idx];
    end

    // node memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            mem_nodes[wr_addr] <= i_node_value[NB-1:0];
        end
        r_node_rd <= mem_nodes[rd_addr];
    end

    // result ports
    assign o_result_valid    = r_out_valid;
    assign o_result_kind     = r_out_kind;
    assign o_hit             = r_out_hit;
    assign o_path_length_out = r_out_len;
    assign o_node_out        = prc_pkg::NODE_W'(r_out_node);
    assign o_last_result     = r_out_last;
    assign o_hit_count       = r_out_hc;
    assign o_miss_count      = r_out_mc;
    assign o_hit_rate        = r_out_rate;

`ifndef SYNTHESIS
    // a store in progress never runs past its length
    a_store_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_store_cnt == '0) || (prc_pkg::LEN_W'(r_store_cnt) < r_store_len))
        else $error("store node counter beyond stored length");

    // a taken lookup holds the block busy for the compare
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req_type == prc_pkg::REQ_LOOKUP)) |=> (busy && (r_state == S_CMP)))
        else $error("lookup not taken into compare");

    // node streaming index stays inside the cached path
    a_node_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NODE) |-> (prc_pkg::LEN_W'(r_j) < r_len))
        else $error("node index beyond path length");

    // divider never yields a rate above one hundred percent
    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_kind == prc_pkg::KIND_STATS))
        |-> (o_hit_rate <= prc_pkg::RATE_W'(prc_pkg::RATE_SCALE)))
        else $error("hit rate out of range");

    // a miss or statistics result carries no path
    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_hit) |-> ((o_path_length_out == '0) && o_last_result))
        else $error("miss or statistics result carries path data");
`endif

endmodule
